// ===== design/key_table_with_sorted_dump_top_defines.svh =====
// Assertion macros used by the key table controller RTL (ktsd_ctrl).
`ifndef KEY_TABLE_WITH_SORTED_DUMP_TOP_DEFINES_SVH
`define KEY_TABLE_WITH_SORTED_DUMP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KTSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KTSD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTSD_ASSERT(label, clk, rst, prop, msg)
`define KTSD_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// ===== design/ktsd_pkg.sv =====
`timescale 1ns / 1ps

package ktsd_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_W = 32;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_DUMP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DELETED   = 3'd3,
      ST_FULL      = 3'd4,
      ST_DUMP_KEY  = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   typedef struct packed {
      status_type              status;
      logic signed [KEY_W-1:0] key;
      logic                    last;
   } beat_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_data;
   } mem_req_type;

endpackage

// ===== design/ktsd_ram.sv =====
`timescale 1ns / 1ps

module ktsd_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ktsd_out.sv =====
`timescale 1ns / 1ps

module ktsd_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  ktsd_pkg::beat_type        push_beat,
   output logic                      push_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic signed [31:0]        rsp_key_out,
   output logic                      rsp_last
);

   logic               valid_ff;
   logic               valid_in;
   ktsd_pkg::beat_type beat_ff;

   assign push_ready = !valid_ff || !rsp_stall;
   assign valid_in   = push_ready ? push_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the beat while stalled
   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         beat_ff <= push_beat;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_status  = beat_ff.status;
   assign rsp_key_out = beat_ff.key;
   assign rsp_last    = beat_ff.last;

endmodule

// ===== design/ktsd_ctrl.sv =====
`timescale 1ns / 1ps
`include "key_table_with_sorted_dump_top_defines.svh"

module ktsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic signed [31:0]     req_key,
   output ktsd_pkg::mem_req_type  mem_req,
   input  logic [31:0]            mem_rd_data,
   output logic                   push_valid,
   output ktsd_pkg::beat_type     push_beat,
   input  logic                   push_ready
);

   localparam int IW = ktsd_pkg::IDX_W;
   localparam int CW = ktsd_pkg::CNT_W;
   localparam int KW = ktsd_pkg::KEY_W;
   localparam logic [CW-1:0] DEPTH = CW'(ktsd_pkg::TABLE_DEPTH);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_RESP      = 9'b000000010,
      S_SCAN      = 9'b000000100,
      S_SHIFT     = 9'b000001000,
      S_SORT_SCAN = 9'b000010000,
      S_SORT_SWAP = 9'b000100000,
      S_SORT_WB   = 9'b001000000,
      S_EMIT_RD   = 9'b010000000,
      S_EMIT      = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   ktsd_pkg::action_type   action_ff, action_in;
   ktsd_pkg::status_type   status_ff, status_in;
   logic [KW-1:0]          key_ff, key_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [IW-1:0]          pass_ff, pass_in;
   logic [IW-1:0]          min_idx_ff, min_idx_in;
   logic [KW-1:0]          min_ff, min_in;
   logic [KW-1:0]          head_ff, head_in;
   logic                   accept;
   logic                   idx_is_tail;
   logic                   take_min;
   ktsd_pkg::action_type   req_act;

   assign req_act     = ktsd_pkg::action_type'(req_action);
   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && (state_ff == S_IDLE);
   assign idx_is_tail = ((CW'(idx_ff) + CW'(1)) == fill_ff);
   assign take_min    = (idx_ff == pass_ff) || ($signed(mem_rd_data) < $signed(min_ff));

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      status_in  = status_ff;
      key_in     = key_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      pass_in    = pass_ff;
      min_idx_in = min_idx_ff;
      min_in     = min_ff;
      head_in    = head_ff;
      mem_req    = '0;
      push_valid = 1'b0;
      push_beat  = '{status: status_ff, key: '0, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in = req_act;
               key_in    = req_key;
               idx_in    = '0;
               pass_in   = '0;
               case (req_act)
                  ktsd_pkg::ACT_INSERT: begin
                     if (fill_ff == DEPTH) begin
                        status_in = ktsd_pkg::ST_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = IW'(fill_ff);
                        mem_req.wr_data = req_key;
                        fill_in         = fill_ff + CW'(1);
                        status_in       = ktsd_pkg::ST_INSERTED;
                     end
                     state_in = S_RESP;
                  end
                  ktsd_pkg::ACT_DELETE, ktsd_pkg::ACT_SEARCH: begin
                     if (fill_ff == '0) begin
                        status_in = ktsd_pkg::ST_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     if (fill_ff == '0) begin
                        status_in = ktsd_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else if (fill_ff == CW'(1)) begin
                        state_in = S_EMIT_RD;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        state_in      = S_SORT_SCAN;
                     end
                  end
               endcase
            end
         end
         S_RESP: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff + IW'(1);
            if (mem_rd_data == key_ff) begin
               if (action_ff == ktsd_pkg::ACT_DELETE) begin
                  state_in = S_SHIFT;
               end else begin
                  status_in = ktsd_pkg::ST_FOUND;
                  state_in  = S_RESP;
               end
            end else if (idx_is_tail) begin
               status_in = ktsd_pkg::ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_SHIFT: begin
            if (idx_is_tail) begin
               fill_in   = fill_ff - CW'(1);
               status_in = ktsd_pkg::ST_DELETED;
               state_in  = S_RESP;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff;
               mem_req.wr_data = mem_rd_data;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + IW'(2);
               idx_in          = idx_ff + IW'(1);
            end
         end
         S_SORT_SCAN: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff + IW'(1);
            if (idx_ff == pass_ff) begin
               head_in = mem_rd_data;
            end
            if (take_min) begin
               min_in     = mem_rd_data;
               min_idx_in = idx_ff;
            end
            if (idx_is_tail) begin
               state_in = S_SORT_SWAP;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_SORT_SWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = min_idx_ff;
            mem_req.wr_data = head_ff;
            state_in        = S_SORT_WB;
         end
         S_SORT_WB: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pass_ff;
            mem_req.wr_data = min_ff;
            if ((CW'(pass_ff) + CW'(2)) < fill_ff) begin
               pass_in         = pass_ff + IW'(1);
               idx_in          = pass_ff + IW'(1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pass_ff + IW'(1);
               state_in        = S_SORT_SCAN;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            push_valid = 1'b1;
            push_beat  = '{status: ktsd_pkg::ST_DUMP_KEY, key: mem_rd_data,
                           last: idx_is_tail};
            if (push_ready) begin
               if (idx_is_tail) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      status_ff  <= status_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      pass_ff    <= pass_in;
      min_idx_ff <= min_idx_in;
      min_ff     <= min_in;
      head_ff    <= head_in;
   end

   `KTSD_ASSERT_NR(a_reset_clears, clock, reset |=> (state_ff == S_IDLE && fill_ff == '0), "reset did not clear control state")
   `KTSD_ASSERT(a_insert_grows, clock, reset, (accept && req_act == ktsd_pkg::ACT_INSERT && fill_ff != DEPTH) |=> (fill_ff == CW'($past(fill_ff) + CW'(1))), "insert did not grow table")
   `KTSD_ASSERT(a_delete_shrinks, clock, reset, (state_ff == S_SHIFT && idx_is_tail) |=> (fill_ff == CW'($past(fill_ff) - CW'(1))), "delete did not shrink table")
   `KTSD_ASSERT(a_write_in_range, clock, reset, mem_req.wr_en |-> (CW'(mem_req.wr_addr) <= fill_ff), "write beyond fill")
   `KTSD_ASSERT(a_last_to_idle, clock, reset, (push_valid && push_ready && push_beat.last) |=> (state_ff == S_IDLE), "last beat did not end item")

endmodule

// ===== design/key_table_with_sorted_dump_top.sv =====
`timescale 1ns / 1ps

// Table of up to 64 signed 32-bit keys in one synchronous RAM, one item at a
// time. Search and delete scan one entry per cycle from the front, and delete
// then shifts the later entries down at one per cycle. Dump sorts in place by
// selection, each pass scanning the unsorted tail at one read per cycle and
// then writing back the swapped pair, and afterwards emits the keys one beat
// at a time, reading each from the RAM first.
// The single RAM read port paces all of these steps. The store needs no
// clearing after reset; only entries below the fill count are ever used.
// Every item ends with a beat that has last set.
module key_table_with_sorted_dump_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_key_out,
   output logic               rsp_last
);

   ktsd_pkg::mem_req_type        mem_req;
   logic [ktsd_pkg::KEY_W-1:0]   mem_rd_data;
   logic                         push_valid;
   logic                         push_ready;
   ktsd_pkg::beat_type           push_beat;

   ktsd_ram #(
      .DEPTH  (ktsd_pkg::TABLE_DEPTH),
      .WIDTH  (ktsd_pkg::KEY_W),
      .ADDR_W (ktsd_pkg::IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   ktsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_key     (req_key),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .push_valid  (push_valid),
      .push_beat   (push_beat),
      .push_ready  (push_ready)
   );

   ktsd_out u_out (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_beat   (push_beat),
      .push_ready  (push_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 10;
   localparam int ITEM_TARGET  = 320;
   localparam int IDLE_PCT     = 29;
   localparam int CALM_FROM    = 140;
   localparam int CALM_TO      = 200;
   localparam int SETTLE       = 200;
   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam int NUM_DIRECTED = 23;
   localparam int KW           = ktsd_pkg::KEY_W;
   localparam int DEPTH        = ktsd_pkg::TABLE_DEPTH;

   typedef enum logic [1:0] {
      MODE_MIX,
      MODE_FILL,
      MODE_DRAIN
   } round_mode_type;

   typedef struct packed {
      ktsd_pkg::action_type act;
      logic signed [KW-1:0] key;
      logic                 typed;
      ktsd_pkg::status_type status;
   } op_row_type;

   localparam op_row_type DIRECTED_OPS [0:NUM_DIRECTED-1] = '{
      '{ktsd_pkg::ACT_DUMP,   32'sd0,         1'b1, ktsd_pkg::ST_EMPTY},
      '{ktsd_pkg::ACT_SEARCH, 32'sd5,         1'b1, ktsd_pkg::ST_NOT_FOUND},
      '{ktsd_pkg::ACT_DELETE, 32'sd5,         1'b1, ktsd_pkg::ST_NOT_FOUND},
      '{ktsd_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_INSERT, 32'sh8000_0000, 1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_INSERT, 32'sd0,         1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_INSERT, -32'sd1,        1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_INSERT, 32'sd7,         1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_INSERT, 32'sd7,         1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_INSERT, 32'sd1,         1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_SEARCH, 32'sh8000_0000, 1'b1, ktsd_pkg::ST_FOUND},
      '{ktsd_pkg::ACT_SEARCH, 32'sh7FFF_FFFF, 1'b1, ktsd_pkg::ST_FOUND},
      '{ktsd_pkg::ACT_SEARCH, 32'sd2,         1'b1, ktsd_pkg::ST_NOT_FOUND},
      '{ktsd_pkg::ACT_DUMP,   -32'sd1,        1'b0, ktsd_pkg::ST_DUMP_KEY},
      '{ktsd_pkg::ACT_DELETE, 32'sd7,         1'b1, ktsd_pkg::ST_DELETED},
      '{ktsd_pkg::ACT_SEARCH, 32'sd7,         1'b1, ktsd_pkg::ST_FOUND},
      '{ktsd_pkg::ACT_DELETE, 32'sd7,         1'b1, ktsd_pkg::ST_DELETED},
      '{ktsd_pkg::ACT_SEARCH, 32'sd7,         1'b1, ktsd_pkg::ST_NOT_FOUND},
      '{ktsd_pkg::ACT_DELETE, 32'sh8000_0000, 1'b1, ktsd_pkg::ST_DELETED},
      '{ktsd_pkg::ACT_INSERT, -32'sd5,        1'b1, ktsd_pkg::ST_INSERTED},
      '{ktsd_pkg::ACT_DUMP,   32'sh5555_AAAA, 1'b0, ktsd_pkg::ST_DUMP_KEY},
      '{ktsd_pkg::ACT_DELETE, 32'sh7FFF_FFFF, 1'b1, ktsd_pkg::ST_DELETED},
      '{ktsd_pkg::ACT_DUMP,   32'sh2AAA_5555, 1'b0, ktsd_pkg::ST_DUMP_KEY}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic signed [31:0] req_key;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_key_out;
   logic               rsp_last;

   logic signed [KW-1:0] table_keys [DEPTH];
   int                   table_fill = 0;
   ktsd_pkg::beat_type   pending_beats [$];
   int                   error_count = 0;
   int                   sent_count = 0;
   int                   cycle_count = 0;
   logic                 calm = 1'b0;

   key_table_with_sorted_dump_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out),
      .rsp_last    (rsp_last)
   );

   task automatic flag_error(string msg);
      $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic void add_beat(bit emit, ktsd_pkg::status_type st,
                                    logic signed [KW-1:0] key, logic last);
      ktsd_pkg::beat_type b;
      b.status = st;
      b.key    = key;
      b.last   = last;
      if (emit) begin
         pending_beats.push_back(b);
      end
   endfunction

   function automatic void apply_table_op(ktsd_pkg::action_type act,
                                          logic signed [KW-1:0] key, bit emit);
      int                   pos;
      int                   i;
      int                   j;
      logic signed [KW-1:0] tmp;
      pos = 0;
      case (act)
         ktsd_pkg::ACT_INSERT: begin
            if (table_fill >= DEPTH) begin
               add_beat(emit, ktsd_pkg::ST_FULL, '0, 1'b1);
            end else begin
               table_keys[table_fill] = key;
               table_fill++;
               add_beat(emit, ktsd_pkg::ST_INSERTED, '0, 1'b1);
            end
         end
         ktsd_pkg::ACT_DELETE, ktsd_pkg::ACT_SEARCH: begin
            while (pos < table_fill && table_keys[pos] != key) pos++;
            if (pos == table_fill) begin
               add_beat(emit, ktsd_pkg::ST_NOT_FOUND, '0, 1'b1);
            end else if (act == ktsd_pkg::ACT_SEARCH) begin
               add_beat(emit, ktsd_pkg::ST_FOUND, '0, 1'b1);
            end else begin
               for (i = pos; i + 1 < table_fill; i++) table_keys[i] = table_keys[i + 1];
               table_fill--;
               add_beat(emit, ktsd_pkg::ST_DELETED, '0, 1'b1);
            end
         end
         default: begin
            if (table_fill == 0) begin
               add_beat(emit, ktsd_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i + 1 < table_fill; i++) begin
                  for (j = i + 1; j < table_fill; j++) begin
                     if (table_keys[i] > table_keys[j]) begin
                        tmp           = table_keys[i];
                        table_keys[i] = table_keys[j];
                        table_keys[j] = tmp;
                     end
                  end
               end
               for (i = 0; i < table_fill; i++) begin
                  add_beat(emit, ktsd_pkg::ST_DUMP_KEY, table_keys[i], i == table_fill - 1);
               end
            end
         end
      endcase
   endfunction

   function automatic logic signed [KW-1:0] pick_key();
      logic signed [KW-1:0] k;
      case ($urandom_range(0, 3))
         0: k = $urandom();
         1: begin
            if (table_fill > 0) begin
               k = table_keys[$urandom_range(0, table_fill - 1)];
            end else begin
               k = $urandom();
            end
         end
         default: k = int'($urandom_range(0, 15)) - 8;
      endcase
      return k;
   endfunction

   task automatic send_op(ktsd_pkg::action_type act, logic signed [KW-1:0] key,
                          logic typed, ktsd_pkg::status_type status);
      logic quiet_now;
      quiet_now = (sent_count >= CALM_FROM && sent_count < CALM_TO);
      calm <= quiet_now;
      while (!quiet_now && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= key;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      if (typed) begin
         add_beat(1'b1, status, '0, 1'b1);
      end
      apply_table_op(act, key, !typed);
      sent_count++;
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
   endtask

   task automatic check_beat();
      ktsd_pkg::beat_type want;
      if (pending_beats.size() == 0) begin
         flag_error($sformatf("unexpected beat status %0d key %0d last %0b",
                              rsp_status, rsp_key_out, rsp_last));
         return;
      end
      want = pending_beats.pop_front();
      if (rsp_status !== want.status) begin
         flag_error($sformatf("status %0d, want %0d", rsp_status, want.status));
      end
      if (rsp_key_out !== want.key) begin
         flag_error($sformatf("key_out %0d, want %0d", rsp_key_out, want.key));
      end
      if (rsp_last !== want.last) begin
         flag_error($sformatf("last %0b, want %0b", rsp_last, want.last));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_beat();
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      round_mode_type mode;
      int             rounds;
      int             pick;
      int             idx;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ktsd_pkg::ACT_INSERT;
      req_key    = '0;
      rounds     = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (idx = 0; idx < NUM_DIRECTED; idx++) begin
         send_op(DIRECTED_OPS[idx].act, DIRECTED_OPS[idx].key, DIRECTED_OPS[idx].typed,
                 DIRECTED_OPS[idx].status);
      end
      wait_for_quiet();

      while (sent_count < ITEM_TARGET) begin
         if (rounds == 1) begin
            mode = MODE_FILL;
         end else if (rounds == 2) begin
            mode = MODE_DRAIN;
         end else begin
            pick = $urandom_range(0, 9);
            mode = (pick < 6) ? MODE_MIX : (pick < 8) ? MODE_FILL : MODE_DRAIN;
         end
         if (rounds == 4) begin
            wait_for_quiet();
         end
         case (mode)
            MODE_FILL: begin
               while (table_fill < DEPTH) begin
                  send_op(ktsd_pkg::ACT_INSERT, pick_key(), 1'b0, ktsd_pkg::ST_INSERTED);
               end
               repeat ($urandom_range(1, 3)) begin
                  send_op(ktsd_pkg::ACT_INSERT, pick_key(), 1'b0, ktsd_pkg::ST_INSERTED);
               end
               send_op(ktsd_pkg::ACT_DUMP, $urandom(), 1'b0, ktsd_pkg::ST_DUMP_KEY);
            end
            MODE_DRAIN: begin
               while (table_fill > 0) begin
                  if ($urandom_range(0, 9) == 0) begin
                     send_op(ktsd_pkg::ACT_DELETE, $urandom(), 1'b0, ktsd_pkg::ST_DELETED);
                  end else begin
                     send_op(ktsd_pkg::ACT_DELETE, table_keys[$urandom_range(0, table_fill - 1)],
                             1'b0, ktsd_pkg::ST_DELETED);
                  end
               end
               send_op(ktsd_pkg::ACT_DUMP, $urandom(), 1'b0, ktsd_pkg::ST_DUMP_KEY);
            end
            default: begin
               repeat (24) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 10) begin
                     send_op(ktsd_pkg::action_type'($urandom_range(0, 3)), $urandom(), 1'b0,
                             ktsd_pkg::ST_INSERTED);
                  end else if (pick < 40) begin
                     send_op(ktsd_pkg::ACT_INSERT, pick_key(), 1'b0, ktsd_pkg::ST_INSERTED);
                  end else if (pick < 62) begin
                     send_op(ktsd_pkg::ACT_DELETE, pick_key(), 1'b0, ktsd_pkg::ST_DELETED);
                  end else if (pick < 86) begin
                     send_op(ktsd_pkg::ACT_SEARCH, pick_key(), 1'b0, ktsd_pkg::ST_FOUND);
                  end else begin
                     send_op(ktsd_pkg::ACT_DUMP, $urandom(), 1'b0, ktsd_pkg::ST_DUMP_KEY);
                  end
               end
            end
         endcase
         rounds++;
      end

      wait_for_quiet();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ktsd_pkg.sv
design/ktsd_ram.sv
design/ktsd_out.sv
design/ktsd_ctrl.sv
design/key_table_with_sorted_dump_top.sv
tb/tb_top.sv
